// ----- sv/brte_pkg.sv -----
// Shared types and constants for the body rate to Euler rate converter.
`timescale 1ns / 1ps

package brte_pkg;

    // Angle folding limits in Q13 radians.
    localparam logic signed [16:0] PI_Q13      = 17'sd25736;
    localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;

    // CORDIC start value of x: the inverse gain in Q30.
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

    // Width of the divider dividend; one quotient bit per divider cell.
    localparam int DIV_W = 47;

    // Output range of the rates.
    localparam logic signed [47:0] RATE_MAX48 = 48'sd8388607;
    localparam logic signed [47:0] RATE_MIN48 = -48'sd8388608;
    localparam logic signed [33:0] RATE_MAX34 = 34'sd8388607;
    localparam logic signed [33:0] RATE_MIN34 = -34'sd8388608;
    localparam logic signed [23:0] RATE_MAX   = 24'sd8388607;
    localparam logic signed [23:0] RATE_MIN   = -24'sd8388608;

    // Truncated Q30 values of atan(2^-i).
    localparam logic [31:0] ATAN_Q30 [0:23] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    // One CORDIC lane as it moves from cell to cell.
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
        logic               neg;
    } t_cordic;

    // Divider state plus the side data that travels along with it.
    typedef struct packed {
        logic [15:0]        rem_a;
        logic [DIV_W-1:0]   num_a;
        logic [15:0]        rem_b;
        logic [DIV_W-1:0]   num_b;
        logic [15:0]        dvs;
        logic               neg_a;
        logic               neg_b;
        logic               sing;
        logic signed [15:0] p;
        logic signed [23:0] pr;
    } t_div;

endpackage

// ----- sv/brte_cordic_cell.sv -----
// One rotation-mode CORDIC micro-rotation with its pipeline register.
`timescale 1ns / 1ps

module brte_cordic_cell #(
    parameter int SHIFT = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  brte_pkg::t_cordic i_d,
    output brte_pkg::t_cordic o_d
);

    localparam logic signed [32:0] ATAN = $signed({1'b0, brte_pkg::ATAN_Q30[SHIFT]});

    brte_pkg::t_cordic r_d;
    brte_pkg::t_cordic n_d;
    logic signed [33:0] w_sx;
    logic signed [33:0] w_sy;

    // Rotate toward zero residual angle.
    always_comb begin
        w_sx = i_d.x >>> SHIFT;
        w_sy = i_d.y >>> SHIFT;
        n_d  = i_d;
        if (!i_d.z[32]) begin
            n_d.x = i_d.x - w_sy;
            n_d.y = i_d.y + w_sx;
            n_d.z = i_d.z - ATAN;
        end else begin
            n_d.x = i_d.x + w_sy;
            n_d.y = i_d.y - w_sx;
            n_d.z = i_d.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// ----- sv/brte_div_cell.sv -----
// One restoring division step for both quotients, with its pipeline register.
`timescale 1ns / 1ps

module brte_div_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  brte_pkg::t_div i_d,
    output brte_pkg::t_div o_d
);

    brte_pkg::t_div r_d;
    brte_pkg::t_div n_d;
    logic [16:0] w_ra;
    logic [16:0] w_rb;
    logic        w_ga;
    logic        w_gb;
    logic [16:0] w_da;
    logic [16:0] w_db;

    // Bring down the next dividend bit and subtract when the divisor fits.
    always_comb begin
        w_ra = {i_d.rem_a, i_d.num_a[brte_pkg::DIV_W-1]};
        w_rb = {i_d.rem_b, i_d.num_b[brte_pkg::DIV_W-1]};
        w_ga = (w_ra >= {1'b0, i_d.dvs});
        w_gb = (w_rb >= {1'b0, i_d.dvs});
        w_da = w_ra - {1'b0, i_d.dvs};
        w_db = w_rb - {1'b0, i_d.dvs};
        n_d       = i_d;
        n_d.rem_a = w_ga ? w_da[15:0] : w_ra[15:0];
        n_d.rem_b = w_gb ? w_db[15:0] : w_rb[15:0];
        n_d.num_a = {i_d.num_a[brte_pkg::DIV_W-2:0], w_ga};
        n_d.num_b = {i_d.num_b[brte_pkg::DIV_W-2:0], w_gb};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

// ----- sv/body_rate_to_euler_rate.sv -----
// Top level of the body angular rate to ZYX Euler angle rate converter.
`timescale 1ns / 1ps

// Converts roll and pitch angles (Q13 rad) and body rates p, q, r (Q11 rad/s)
// into Euler angle rates (Q11 rad/s, saturated to 24 bits). The block is a
// single pipeline that takes one request per clock while it is not stalled,
// made of one input stage, a row of CORDIC cells (one per stage, roll and
// pitch side by side), five stages of products and rounding, 47 restoring
// divider cells (one quotient bit each, both quotients in parallel), and the
// output register. When a valid result is stalled at the output the whole
// pipeline holds and the input is stalled in the same cycle. When
// |cos(pitch)| falls below cos_threshold (Q0.15) or is zero, all rates are
// zero and singular is set. The threshold is written through the cfg port,
// which is always ready, and should only be written while the block is empty.
module body_rate_to_euler_rate #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_roll_angle,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_body_rate_p,
    input  logic signed [15:0] i_body_rate_q,
    input  logic signed [15:0] i_body_rate_r,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [23:0] o_roll_rate,
    output logic signed [23:0] o_pitch_rate,
    output logic signed [23:0] o_yaw_rate,
    output logic               o_singular,
    output logic               o_saturated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [14:0]        i_cfg_data
);

    localparam int S   = CORDIC_STAGES;
    localparam int DW  = brte_pkg::DIV_W;
    localparam int LAT = S + DW + 7;

    logic           w_en;
    logic [LAT-1:0] r_vld;
    logic [14:0]    r_cos_thr;

    // Pipeline advances unless a finished result is held by the consumer.
    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_thr <= 15'd1;
        end else if (i_cfg_valid) begin
            r_cos_thr <= i_cfg_data;
        end
    end

    // Input stage: fold angles into [-pi/2, pi/2] and seed the CORDIC.
    brte_pkg::t_cordic w_roll  [0:S];
    brte_pkg::t_cordic w_pitch [0:S];
    brte_pkg::t_cordic r_roll0;
    brte_pkg::t_cordic r_pitch0;
    brte_pkg::t_cordic n_roll0;
    brte_pkg::t_cordic n_pitch0;
    logic signed [15:0] r_sp [0:S];
    logic signed [15:0] r_sq [0:S];
    logic signed [15:0] r_sr [0:S];

    function automatic brte_pkg::t_cordic fold(input logic signed [15:0] a);
        logic signed [16:0] v;
        brte_pkg::t_cordic  c;
        v = 17'(a);
        c.neg = 1'b0;
        if (v > brte_pkg::HALF_PI_Q13) begin
            v     = v - brte_pkg::PI_Q13;
            c.neg = 1'b1;
        end else if (v < -brte_pkg::HALF_PI_Q13) begin
            v     = v + brte_pkg::PI_Q13;
            c.neg = 1'b1;
        end
        c.x = brte_pkg::GAIN_Q30;
        c.y = '0;
        c.z = {v[15:0], 17'b0};
        return c;
    endfunction

    always_comb begin
        n_roll0  = fold(i_roll_angle);
        n_pitch0 = fold(i_pitch_angle);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_roll0  <= n_roll0;
            r_pitch0 <= n_pitch0;
            r_sp[0]  <= i_body_rate_p;
            r_sq[0]  <= i_body_rate_q;
            r_sr[0]  <= i_body_rate_r;
            for (int k = 0; k < S; k++) begin
                r_sp[k+1] <= r_sp[k];
                r_sq[k+1] <= r_sq[k];
                r_sr[k+1] <= r_sr[k];
            end
        end
    end

    assign w_roll[0]  = r_roll0;
    assign w_pitch[0] = r_pitch0;

    // Row of CORDIC cells, one per micro-rotation.
    for (genvar g = 0; g < S; g++) begin : g_cordic
        brte_cordic_cell #(.SHIFT(g)) u_roll (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_roll[g]),
            .o_d   (w_roll[g+1])
        );
        brte_cordic_cell #(.SHIFT(g)) u_pitch (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_pitch[g]),
            .o_d   (w_pitch[g+1])
        );
    end

    // Stage P1: round sine and cosine to Q15, test for the singularity.
    function automatic logic signed [17:0] rnd15(input logic signed [33:0] v,
                                                 input logic neg);
        logic signed [33:0] t;
        t = (neg ? -v : v) + 34'sd16384;
        return t[32:15];
    endfunction

    logic signed [17:0] r1_sr, r1_cr, r1_sp, r1_cp;
    logic               r1_sing;
    logic signed [15:0] r1_p, r1_q, r1_r;
    logic signed [17:0] w1_cp;
    logic signed [17:0] w1_acp;

    always_comb begin
        w1_cp  = rnd15(w_pitch[S].x, w_pitch[S].neg);
        w1_acp = w1_cp[17] ? -w1_cp : w1_cp;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_sr   <= rnd15(w_roll[S].y, w_roll[S].neg);
            r1_cr   <= rnd15(w_roll[S].x, w_roll[S].neg);
            r1_sp   <= rnd15(w_pitch[S].y, w_pitch[S].neg);
            r1_cp   <= w1_cp;
            r1_sing <= (w1_cp == 18'sd0) || (w1_acp[16:0] < {2'b0, r_cos_thr});
            r1_p    <= r_sp[S];
            r1_q    <= r_sq[S];
            r1_r    <= r_sr[S];
        end
    end

    // Stage P2: the four rate products.
    logic signed [33:0] r2_m1, r2_m2, r2_m3, r2_m4;
    logic signed [17:0] r2_sp, r2_cp;
    logic               r2_sing;
    logic signed [15:0] r2_p;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_m1   <= r1_sr * r1_q;
            r2_m2   <= r1_cr * r1_r;
            r2_m3   <= r1_cr * r1_q;
            r2_m4   <= r1_sr * r1_r;
            r2_sp   <= r1_sp;
            r2_cp   <= r1_cp;
            r2_sing <= r1_sing;
            r2_p    <= r1_p;
        end
    end

    // Stage P3: sums.
    logic signed [34:0] r3_a, r3_pq;
    logic signed [17:0] r3_sp, r3_cp;
    logic               r3_sing;
    logic signed [15:0] r3_p;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_a    <= 35'(r2_m1) + 35'(r2_m2);
            r3_pq   <= 35'(r2_m3) - 35'(r2_m4);
            r3_sp   <= r2_sp;
            r3_cp   <= r2_cp;
            r3_sing <= r2_sing;
            r3_p    <= r2_p;
        end
    end

    // Stage P4: sin(pitch) times A, and the rounded pitch rate.
    logic signed [52:0] r4_prod;
    logic signed [34:0] r4_a;
    logic signed [17:0] r4_cp;
    logic               r4_sing;
    logic signed [15:0] r4_p;
    logic signed [23:0] r4_pr;
    logic signed [34:0] w4_t;

    assign w4_t = r3_pq + 35'sd16384;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_prod <= r3_sp * r3_a;
            r4_a    <= r3_a;
            r4_cp   <= r3_cp;
            r4_sing <= r3_sing;
            r4_p    <= r3_p;
            r4_pr   <= 24'($signed(w4_t[34:15]));
        end
    end

    // Stage P5: magnitudes and signs for the divider.
    brte_pkg::t_div     r5_d;
    brte_pkg::t_div     n5_d;
    brte_pkg::t_div     w_div [0:DW];
    logic signed [34:0] w5_ma;
    logic signed [52:0] w5_mb;
    logic signed [17:0] w5_acp;

    always_comb begin
        w5_ma  = r4_a[34] ? -r4_a : r4_a;
        w5_mb  = r4_prod[52] ? -r4_prod : r4_prod;
        w5_acp = r4_cp[17] ? -r4_cp : r4_cp;
        n5_d.rem_a = '0;
        n5_d.rem_b = '0;
        n5_d.num_a = {{(DW-34){1'b0}}, w5_ma[33:0]};
        n5_d.num_b = w5_mb[DW-1:0];
        n5_d.dvs   = w5_acp[15:0];
        n5_d.neg_a = r4_a[34] ^ r4_cp[17];
        n5_d.neg_b = r4_prod[52] ^ r4_cp[17];
        n5_d.sing  = r4_sing;
        n5_d.p     = r4_p;
        n5_d.pr    = r4_pr;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_d <= n5_d;
        end
    end

    assign w_div[0] = r5_d;

    // Row of divider cells.
    for (genvar g = 0; g < DW; g++) begin : g_div
        brte_div_cell u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_div[g]),
            .o_d   (w_div[g+1])
        );
    end

    // Output stage: sign, rounding, add p, saturate.
    brte_pkg::t_div     w_f;
    logic signed [47:0] w_qa, w_ya, w_qb, w_yb, w_rb;
    logic signed [33:0] w_rr;
    logic               w_sat_y, w_sat_r;
    logic signed [23:0] w_yr, w_rl;
    logic signed [23:0] r_roll, r_pitch, r_yaw;
    logic               r_sing, r_sat;

    always_comb begin
        w_f  = w_div[DW];
        w_qa = $signed({1'b0, w_f.num_a});
        w_qb = $signed({1'b0, w_f.num_b});
        w_ya = w_f.neg_a ? -w_qa : w_qa;
        w_yb = w_f.neg_b ? -w_qb : w_qb;
        w_rb = w_yb + 48'sd16384;
        w_rr = 34'(w_f.p) + 34'($signed(w_rb[47:15]));
        w_sat_y = 1'b0;
        w_sat_r = 1'b0;
        if (w_ya > brte_pkg::RATE_MAX48) begin
            w_yr = brte_pkg::RATE_MAX;
            w_sat_y = 1'b1;
        end else if (w_ya < brte_pkg::RATE_MIN48) begin
            w_yr = brte_pkg::RATE_MIN;
            w_sat_y = 1'b1;
        end else begin
            w_yr = w_ya[23:0];
        end
        if (w_rr > brte_pkg::RATE_MAX34) begin
            w_rl = brte_pkg::RATE_MAX;
            w_sat_r = 1'b1;
        end else if (w_rr < brte_pkg::RATE_MIN34) begin
            w_rl = brte_pkg::RATE_MIN;
            w_sat_r = 1'b1;
        end else begin
            w_rl = w_rr[23:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_f.sing) begin
                r_roll  <= '0;
                r_pitch <= '0;
                r_yaw   <= '0;
                r_sing  <= 1'b1;
                r_sat   <= 1'b0;
            end else begin
                r_roll  <= w_rl;
                r_pitch <= w_f.pr;
                r_yaw   <= w_yr;
                r_sing  <= 1'b0;
                r_sat   <= w_sat_y | w_sat_r;
            end
        end
    end

    assign o_roll_rate  = r_roll;
    assign o_pitch_rate = r_pitch;
    assign o_yaw_rate   = r_yaw;
    assign o_singular   = r_sing;
    assign o_saturated  = r_sat;

    // A singular result carries zero rates and no saturation.
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_singular) |-> (o_roll_rate == 24'sd0 && o_pitch_rate == 24'sd0
            && o_yaw_rate == 24'sd0 && !o_saturated))
        else $error("singular result with nonzero rates");

    // Saturation is only flagged when roll or yaw sits at a range limit.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |-> (o_roll_rate == brte_pkg::RATE_MAX
            || o_roll_rate == brte_pkg::RATE_MIN || o_yaw_rate == brte_pkg::RATE_MAX
            || o_yaw_rate == brte_pkg::RATE_MIN))
        else $error("saturated flag without a clipped rate");

    // The pitch rate is bounded well inside the 24-bit range.
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pitch_rate < 24'sd131072 && o_pitch_rate > -24'sd131072))
        else $error("pitch rate out of its natural range");

endmodule

// ----- test/body_rate_to_euler_rate_tb.sv -----
// Self-checking testbench for the body rate to Euler rate converter.
`timescale 1ns / 1ps

module body_rate_to_euler_rate_tb;

    localparam int STAGES    = 16;
    localparam int LATENCY   = STAGES + 54;
    localparam int LIMIT     = 400000;
    localparam int N_RANDOM  = 950;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] p;
        logic signed [15:0] q;
        logic signed [15:0] r;
    } t_request;

    typedef struct packed {
        logic signed [23:0] roll_rate;
        logic signed [23:0] pitch_rate;
        logic signed [23:0] yaw_rate;
        logic               singular;
        logic               saturated;
    } t_rates;

    // Directed row: request, optional typed-in expectation.
    typedef struct {
        t_request req;
        bit       fixed;
        t_rates   rates;
    } t_row;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               out_stall = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [14:0]        cfg_data = 15'd0;
    t_request           req_q = '0;
    logic               dut_stall;
    logic               dut_valid;
    logic               cfg_ready;
    logic signed [23:0] dut_roll, dut_pitch, dut_yaw;
    logic               dut_sing, dut_sat;

    t_rates   expected_rates[$];
    logic [14:0] threshold = 15'd1;
    int       mismatches = 0;
    int       cycles = 0;
    int       send_idle = 0;
    int       recv_idle = 0;

    body_rate_to_euler_rate #(.CORDIC_STAGES(STAGES)) i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(dut_stall),
        .i_roll_angle(req_q.roll), .i_pitch_angle(req_q.pitch),
        .i_body_rate_p(req_q.p), .i_body_rate_q(req_q.q), .i_body_rate_r(req_q.r),
        .o_valid(dut_valid), .i_stall(out_stall),
        .o_roll_rate(dut_roll), .o_pitch_rate(dut_pitch), .o_yaw_rate(dut_yaw),
        .o_singular(dut_sing), .o_saturated(dut_sat),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round_q15(longint v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    // Folded rotation-mode CORDIC giving Q15 sine and cosine.
    function automatic void cordic_sin_cos(input longint ang, output longint s,
                                           output longint c);
        longint x, y, z, nx;
        bit     neg;
        x = brte_pkg::GAIN_Q30;
        y = 0;
        neg = 0;
        if (ang > brte_pkg::HALF_PI_Q13) begin
            ang -= brte_pkg::PI_Q13;
            neg = 1;
        end else if (ang < -brte_pkg::HALF_PI_Q13) begin
            ang += brte_pkg::PI_Q13;
            neg = 1;
        end
        z = ang * 131072;
        for (int i = 0; i < STAGES && i < 24; i++) begin
            if (z >= 0) begin
                nx = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                z -= longint'(brte_pkg::ATAN_Q30[i]);
            end else begin
                nx = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                z += longint'(brte_pkg::ATAN_Q30[i]);
            end
            x = nx;
        end
        c = round_q15(neg ? -x : x);
        s = round_q15(neg ? -y : y);
    endfunction

    function automatic longint clip_rate(longint v, inout bit sat);
        if (v > 8388607) begin
            sat = 1;
            return 8388607;
        end
        if (v < -8388608) begin
            sat = 1;
            return -8388608;
        end
        return v;
    endfunction

    // Euler rate computation for one request.
    function automatic t_rates euler_rates(t_request rq);
        longint sr, cr, sp, cp, acp, a, rr, pr, yr;
        bit     sat;
        t_rates res;
        sat = 0;
        res = '0;
        cordic_sin_cos(rq.roll, sr, cr);
        cordic_sin_cos(rq.pitch, sp, cp);
        acp = cp < 0 ? -cp : cp;
        if (cp == 0 || acp < longint'(threshold)) begin
            res.singular = 1'b1;
            return res;
        end
        a = sr * rq.q + cr * rq.r;
        pr = round_q15(cr * rq.q - sr * rq.r);
        yr = a / cp;
        rr = longint'(rq.p) + round_q15((sp * a) / cp);
        res.roll_rate = 24'(clip_rate(rr, sat));
        res.pitch_rate = 24'(clip_rate(pr, sat));
        res.yaw_rate = 24'(clip_rate(yr, sat));
        res.saturated = sat;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, want %0d", what, got, want);
        mismatches++;
    endtask

    // Cycle limit and output checking.
    always @(posedge clk) begin
        t_rates want;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
        if (rst_n && dut_valid && !out_stall) begin
            if (expected_rates.size() == 0) begin
                report_mismatch("unexpected result", 0, 0);
            end else begin
                want = expected_rates.pop_front();
                if (dut_roll !== want.roll_rate)
                    report_mismatch("roll_rate", dut_roll, want.roll_rate);
                if (dut_pitch !== want.pitch_rate)
                    report_mismatch("pitch_rate", dut_pitch, want.pitch_rate);
                if (dut_yaw !== want.yaw_rate)
                    report_mismatch("yaw_rate", dut_yaw, want.yaw_rate);
                if (dut_sing !== want.singular)
                    report_mismatch("singular", dut_sing, want.singular);
                if (dut_sat !== want.saturated)
                    report_mismatch("saturated", dut_sat, want.saturated);
            end
        end
    end

    // Receiver stalls at the current phase's rate.
    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    // Send one request and queue its expectation when accepted. Valid stays
    // high after acceptance so that requests can follow back to back.
    task automatic send_request(t_request rq, bit fixed, t_rates rates);
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        req_q <= rq;
        in_valid <= 1'b1;
        @(posedge clk);
        while (dut_stall) @(posedge clk);
        expected_rates.push_back(fixed ? rates : euler_rates(rq));
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (expected_rates.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_threshold(logic [14:0] value);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        threshold = value;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(5))
            0: return 16'($urandom);
            1: return 16'($urandom_range(200)) - 16'sd100 + 16'sd12868;
            2: return 16'sd100 - 16'($urandom_range(200)) - 16'sd12868;
            default: return 16'($urandom_range(51472)) - 16'sd25736;
        endcase
    endfunction

    function automatic t_request rand_request();
        t_request rq;
        rq.roll = rand_angle();
        rq.pitch = rand_angle();
        rq.p = 16'($urandom);
        rq.q = 16'($urandom);
        rq.r = 16'($urandom);
        return rq;
    endfunction

    initial begin
        t_row   rows[$];
        t_row   row;
        t_rates zero_sing;
        t_rates none;
        logic [14:0] thresholds[4];
        int     phase;
        zero_sing = '0;
        zero_sing.singular = 1'b1;
        none = '0;
        thresholds = '{15'd1, 15'd0, 15'd32767, 15'd3000};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: extremes, folding edges and the singularity.
        rows.push_back('{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, none});
        rows.push_back('{'{16'sd0, 16'sd12868, 16'sd5, 16'sd5, 16'sd5}, 0, zero_sing});
        rows.push_back('{'{16'sd0, -16'sd12868, 16'sd1, 16'sd1, 16'sd1}, 0, zero_sing});
        rows.push_back('{'{16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0}, 1,
                         '{24'sd32767, 24'sd0, 24'sd0, 1'b0, 1'b0}});
        rows.push_back('{'{16'sd0, 16'sd0, -16'sd32768, 16'sd0, 16'sd0}, 1,
                         '{-24'sd32768, 24'sd0, 24'sd0, 1'b0, 1'b0}});
        rows.push_back('{'{16'sd25736, 16'sd12000, 16'sd32767, 16'sd32767, 16'sd32767},
                         0, none});
        rows.push_back('{'{-16'sd25736, -16'sd12000, -16'sd32768, -16'sd32768,
                           -16'sd32768}, 0, none});
        rows.push_back('{'{16'sd12868, 16'sd12867, 16'sd0, 16'sd32767, -16'sd32768},
                         0, none});
        rows.push_back('{'{16'sd12869, 16'sd12869, 16'sd0, -16'sd32768, 16'sd32767},
                         0, none});
        rows.push_back('{'{-16'sd12869, 16'sd12850, 16'sd0, 16'sd32767, 16'sd32767},
                         0, none});
        rows.push_back('{'{16'sh7FFF, 16'sh8000, 16'sd1, 16'sd2, 16'sd3}, 0, none});
        rows.push_back('{'{16'sh8000, 16'sh7FFF, -16'sd1, -16'sd2, -16'sd3}, 0, none});
        rows.push_back('{'{16'sd6434, 16'sd12860, 16'sd32767, 16'sd32767, 16'sd32767},
                         0, none});
        rows.push_back('{'{-16'sd6434, -16'sd12860, -16'sd32768, -16'sd32768,
                           -16'sd32768}, 0, none});
        foreach (rows[i]) begin
            row = rows[i];
            send_request(row.req, row.fixed, row.rates);
        end
        drain_pipeline();

        // Random phases over several thresholds and idling mixes.
        for (int k = 0; k < 4; k++) begin
            write_threshold(thresholds[k]);
            send_request('{16'sd0, 16'sd12868, 16'sd0, 16'sd7, 16'sd7}, 0, none);
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                phase = (n * 4) / (N_RANDOM / 4);
                send_idle = (phase == 1 || phase == 3) ? ((phase == 1) ? 62 : 34) : 0;
                recv_idle = (phase == 2 || phase == 3) ? ((phase == 2) ? 62 : 34) : 0;
                if (n == 40) drain_pipeline();
                send_request(rand_request(), 0, none);
            end
            send_idle = 0;
            recv_idle = 0;
            drain_pipeline();
        end

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
